// File: src/qdv_pkg.sv
// Shared types, constants and the x4 transition decode for the quadrature decoder.
package qdv_pkg;

    localparam int WINDOW_DEFAULT = 8;
    localparam int VEL_SCALE      = 16000;   // 1000 ms/s times 16 for the q4 fraction
    localparam int VEL_LIMIT      = 131071;

    localparam int POS_W       = 32;
    localparam int TIME_W      = 32;
    localparam int VEL_W       = 18;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;

    typedef logic signed [1:0] step_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECORD,
        ST_SCALE,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    // x4 decode: index is {prev B, prev A, cur B, cur A}
    function automatic step_t quad_step(input logic [1:0] prev, input logic [1:0] cur);
        step_t s;
        case ({prev, cur})
            4'b0001: s = -2'sd1;
            4'b0010: s = 2'sd1;
            4'b0100: s = 2'sd1;
            4'b0111: s = -2'sd1;
            4'b1000: s = -2'sd1;
            4'b1011: s = 2'sd1;
            4'b1101: s = 2'sd1;
            4'b1110: s = -2'sd1;
            default: s = 2'sd0;
        endcase
        return s;
    endfunction

endpackage

// File: src/quadrature_decoder_velocity.sv
// Quadrature x4 decoder with a windowed velocity estimate from a serial divider.
//
// One transaction on the input stream carries a pin sample and its millisecond
// timestamp; each one yields exactly one result with position, step and velocity
// (counts per second, 4 fraction bits, truncated toward zero, 0 while no time has
// been recorded). The first sample after reset only primes the pin state and the
// reference time. Steps and intervals of the last WINDOW counted transitions sit
// in a small ring memory whose running sums feed a restoring divider that yields
// one quotient bit per cycle. After acceptance an item passes the record, scale,
// divide and output states before the next ready; divide is skipped when the
// interval sum is zero, and output waits for a free output register. The input
// is not ready while an item is being worked on. Ring entries reset to zero
// through per-entry valid bits, so no clearing pass is needed.
module quadrature_decoder_velocity #(
    parameter int WINDOW = qdv_pkg::WINDOW_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] pin_a_level, [1] pin_b_level, [33:2] time_ms, [39:34] zero
    input  logic [qdv_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] position_count, [33:32] step_taken, [51:34] velocity_q4, [55:52] zero
    output logic [qdv_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SSUM_W = $clog2(WINDOW + 1) + 1;
    localparam int ISUM_W = qdv_pkg::TIME_W + $clog2(WINDOW);
    localparam int NUM_W  = $clog2(WINDOW * qdv_pkg::VEL_SCALE + 1);
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int PAD_W  = qdv_pkg::OUT_TDATA_W - qdv_pkg::POS_W - 2 - qdv_pkg::VEL_W;

    qdv_pkg::state_t state_reg, state_next;

    logic [1:0]                      prev_pins_reg, prev_pins_next;
    logic                            primed_reg, primed_next;
    logic signed [qdv_pkg::POS_W-1:0] count_reg, count_next;
    logic [qdv_pkg::TIME_W-1:0]      last_change_reg, last_change_next;
    logic [qdv_pkg::TIME_W-1:0]      elapsed_reg, elapsed_next;
    qdv_pkg::step_t                  step_reg, step_next;
    logic [SLOT_W-1:0]               slot_reg, slot_next;
    logic [WINDOW-1:0]               valid_reg, valid_next;
    logic signed [SSUM_W-1:0]        step_sum_reg, step_sum_next;
    logic [ISUM_W-1:0]               isum_reg, isum_next;

    logic [NUM_W-1:0]                num_reg, num_next;
    logic [NUM_W-1:0]                quo_reg, quo_next;
    logic [ISUM_W-1:0]               rem_reg, rem_next;
    logic [CNT_W-1:0]                bit_cnt_reg, bit_cnt_next;
    logic                            sign_reg, sign_next;

    logic                            m_valid_reg, m_valid_next;
    logic [qdv_pkg::OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    // ring memory
    qdv_pkg::step_t                  step_mem [WINDOW];
    logic [qdv_pkg::TIME_W-1:0]      int_mem  [WINDOW];
    qdv_pkg::step_t                  rd_step_reg;
    logic [qdv_pkg::TIME_W-1:0]      rd_int_reg;
    logic                            mem_we;

    logic [1:0]                      in_pins;
    logic [qdv_pkg::TIME_W-1:0]      in_time;
    qdv_pkg::step_t                  old_step;
    logic [qdv_pkg::TIME_W-1:0]      old_int;
    logic [SSUM_W-1:0]               ssum_mag;
    logic [ISUM_W:0]                 rem_sh;
    logic [qdv_pkg::VEL_W-1:0]       vel_mag;
    logic [qdv_pkg::VEL_W-1:0]       vel_out;

    assign in_pins = {s_axis_tdata[1], s_axis_tdata[0]};
    assign in_time = s_axis_tdata[qdv_pkg::TIME_W+1:2];

    assign s_axis_tready = (state_reg == qdv_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // entries never written read as zero
    assign old_step = valid_reg[slot_reg] ? rd_step_reg : 2'sd0;
    assign old_int  = valid_reg[slot_reg] ? rd_int_reg : '0;

    assign ssum_mag = step_sum_reg[SSUM_W-1] ? SSUM_W'(-step_sum_reg) : SSUM_W'(step_sum_reg);
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};

    assign vel_mag = (32'(quo_reg) > 32'(qdv_pkg::VEL_LIMIT)) ?
                     qdv_pkg::VEL_W'(qdv_pkg::VEL_LIMIT) : qdv_pkg::VEL_W'(quo_reg);
    assign vel_out = sign_reg ? qdv_pkg::VEL_W'(-vel_mag) : vel_mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= qdv_pkg::ST_IDLE;
            prev_pins_reg   <= '0;
            primed_reg      <= 1'b0;
            count_reg       <= '0;
            last_change_reg <= '0;
            slot_reg        <= '0;
            valid_reg       <= '0;
            step_sum_reg    <= '0;
            isum_reg        <= '0;
            bit_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            prev_pins_reg   <= prev_pins_next;
            primed_reg      <= primed_next;
            count_reg       <= count_next;
            last_change_reg <= last_change_next;
            slot_reg        <= slot_next;
            valid_reg       <= valid_next;
            step_sum_reg    <= step_sum_next;
            isum_reg        <= isum_next;
            bit_cnt_reg     <= bit_cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        elapsed_reg <= elapsed_next;
        step_reg    <= step_next;
        num_reg     <= num_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        sign_reg    <= sign_next;
        m_data_reg  <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            step_mem[slot_reg] <= step_reg;
            int_mem[slot_reg]  <= elapsed_reg;
        end
        rd_step_reg <= step_mem[slot_reg];
        rd_int_reg  <= int_mem[slot_reg];
    end

    always_comb begin
        state_next       = state_reg;
        prev_pins_next   = prev_pins_reg;
        primed_next      = primed_reg;
        count_next       = count_reg;
        last_change_next = last_change_reg;
        elapsed_next     = elapsed_reg;
        step_next        = step_reg;
        slot_next        = slot_reg;
        valid_next       = valid_reg;
        step_sum_next    = step_sum_reg;
        isum_next        = isum_reg;
        num_next         = num_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        bit_cnt_next     = bit_cnt_reg;
        sign_next        = sign_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        mem_we           = 1'b0;

        case (state_reg)
            qdv_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    elapsed_next = in_time - last_change_reg;
                    step_next    = 2'sd0;
                    if (!primed_reg) begin
                        prev_pins_next   = in_pins;
                        last_change_next = in_time;
                        primed_next      = 1'b1;
                    end else begin
                        step_next      = qdv_pkg::quad_step(prev_pins_reg, in_pins);
                        prev_pins_next = in_pins;
                        if (step_next != 2'sd0) begin
                            count_next       = count_reg + qdv_pkg::POS_W'(step_next);
                            last_change_next = in_time;
                        end
                    end
                    state_next = qdv_pkg::ST_RECORD;
                end
            end
            qdv_pkg::ST_RECORD: begin
                // replace the oldest ring entry and keep the sums in step
                if (step_reg != 2'sd0) begin
                    mem_we                = 1'b1;
                    step_sum_next         = step_sum_reg - SSUM_W'(old_step) + SSUM_W'(step_reg);
                    isum_next             = isum_reg - ISUM_W'(old_int) + ISUM_W'(elapsed_reg);
                    valid_next[slot_reg]  = 1'b1;
                    slot_next             = (32'(slot_reg) == WINDOW - 1) ?
                                            '0 : SLOT_W'(slot_reg + 1'b1);
                end
                state_next = qdv_pkg::ST_SCALE;
            end
            qdv_pkg::ST_SCALE: begin
                num_next     = NUM_W'(32'(ssum_mag) * 32'(qdv_pkg::VEL_SCALE));
                sign_next    = step_sum_reg[SSUM_W-1];
                rem_next     = '0;
                quo_next     = '0;
                bit_cnt_next = CNT_W'(NUM_W - 1);
                if (isum_reg == '0) begin
                    sign_next  = 1'b0;
                    state_next = qdv_pkg::ST_OUTPUT;
                end else begin
                    state_next = qdv_pkg::ST_DIVIDE;
                end
            end
            qdv_pkg::ST_DIVIDE: begin
                // restoring division, one quotient bit per cycle
                if (rem_sh >= {1'b0, isum_reg}) begin
                    rem_next = ISUM_W'(rem_sh - {1'b0, isum_reg});
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_next = ISUM_W'(rem_sh);
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                if (bit_cnt_reg == '0) begin
                    state_next = qdv_pkg::ST_OUTPUT;
                end else begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            qdv_pkg::ST_OUTPUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_axis_tready) begin
                    m_data_next  = {{PAD_W{1'b0}}, vel_out, step_reg, count_reg};
                    m_valid_next = 1'b1;
                    state_next   = qdv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = qdv_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/qdv_checker.sv
// Port-level assertions for the quadrature decoder, bound to its top level.
module qdv_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [qdv_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [qdv_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // one item at a time: ready drops right after a transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still ready after a transaction");

    a_step_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[33:32] != 2'b10)
        else $error("step_taken outside -1..+1");

    a_vel_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[51:34] != 18'h20000)
        else $error("velocity beyond saturation limit");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[55:52] == 4'b0000)
        else $error("result padding not zero");

endmodule

bind quadrature_decoder_velocity qdv_checker u_qdv_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
